/* src/snl_pkg.sv */
// ----------------------------------------------------------------------------
// snl_pkg: shared types and constants for the sum normalizer
// Field widths, word structs, status codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package snl_pkg;

  localparam int DATA_W           = 32;  // Q format entry width
  localparam int SUM_W            = 38;  // running sum width
  localparam int MAX_ENTRIES_DEF  = 64;
  localparam int FRAC_BITS_DEF    = 16;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_ZERO_SUM = 2'd1,
    STATUS_NEG_TGT  = 2'd2,
    STATUS_OVERFLOW = 2'd3
  } status_e;

  typedef struct packed {
    logic [DATA_W-1:0] flux_value;
    logic              is_locked;
    logic [DATA_W-1:0] lock_target;
    logic              last_entry;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] scaled_value;
    logic              final_result;
    status_e           status_code;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_READ,
    ST_MUL,
    ST_DIV_INIT,
    ST_DIV,
    ST_EMIT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic setup;
    logic rd;
    logic mul;
    logic div_init;
    logic div_step;
    logic emit;
    logic clear;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic bypass;
    logic sat;
    logic div_last;
    logic last_idx;
  } sts_t;

endpackage

/* src/snl_dpath.sv */
// ----------------------------------------------------------------------------
// snl_dpath: sum normalizer datapath
// Entry memory, running sums, target setup, one multiplier and a
// radix-2 restoring divider.
// ----------------------------------------------------------------------------
module snl_dpath import snl_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cmd_t    cmd_i,
  input  item_t   item_i,
  output sts_t    sts_o,
  output result_t result_o
);

  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int TGT_W  = CNT_W + FRAC_BITS;
  localparam int PROD_W = DATA_W + TGT_W;
  localparam int DCNT_W = $clog2(DATA_W);

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              locked;
    logic [DATA_W-1:0] target;
  } mem_word_t;

  mem_word_t         mem_q [MAX_ENTRIES];
  mem_word_t         rd_q;

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [SUM_W-1:0]  total_q, total_d;
  logic [SUM_W-1:0]  locked_q, locked_d;
  logic              ovf_q, ovf_d;

  logic [SUM_W-1:0]  unl_q;
  logic [TGT_W-1:0]  tgt_q;
  logic              uz_q;
  logic              neg_q;
  status_e           status_q;

  logic [PROD_W-1:0] prod_q;
  logic [SUM_W-1:0]  rem_q;
  logic [DATA_W-1:0] quo_q;
  logic [DCNT_W-1:0] dcnt_q;
  logic [DATA_W-1:0] res_q;

  logic              room;
  logic [TGT_W-1:0]  full;
  logic [SUM_W-1:0]  full_ext;
  logic [SUM_W-1:0]  unl_d;
  logic              neg_d;
  logic              uz_d;
  logic [TGT_W-1:0]  prod_hi;
  logic [SUM_W:0]    trial;
  logic [SUM_W:0]    diff;
  logic              ge;
  logic [SUM_W-1:0]  rem_d;
  logic [DATA_W-1:0] quo_d;

  assign room     = cnt_q < CNT_W'(MAX_ENTRIES);
  assign full     = {cnt_q, {FRAC_BITS{1'b0}}};
  assign full_ext = {{(SUM_W-TGT_W){1'b0}}, full};
  assign unl_d    = total_q - locked_q;
  assign neg_d    = locked_q > full_ext;
  assign uz_d     = unl_d == '0;

  assign prod_hi  = prod_q[PROD_W-1:DATA_W];

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_q, quo_q[DATA_W-1]};
  assign diff  = trial - {1'b0, unl_q};
  assign ge    = trial >= {1'b0, unl_q};
  assign rem_d = ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
  assign quo_d = {quo_q[DATA_W-2:0], ge};

  always_comb begin
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    total_d  = total_q;
    locked_d = locked_q;
    ovf_d    = ovf_q;
    if (cmd_i.clear) begin
      cnt_d    = '0;
      idx_d    = '0;
      total_d  = '0;
      locked_d = '0;
      ovf_d    = 1'b0;
    end else if (cmd_i.load) begin
      if (room) begin
        cnt_d   = cnt_q + CNT_W'(1);
        total_d = total_q + {{(SUM_W-DATA_W){1'b0}}, item_i.flux_value};
        if (item_i.is_locked) begin
          locked_d = locked_q + {{(SUM_W-DATA_W){1'b0}}, item_i.flux_value};
        end
      end else begin
        ovf_d = 1'b1;
      end
    end else if (cmd_i.setup) begin
      idx_d = '0;
    end else if (cmd_i.emit) begin
      idx_d = idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      idx_q    <= '0;
      total_q  <= '0;
      locked_q <= '0;
      ovf_q    <= 1'b0;
      dcnt_q   <= '0;
    end else begin
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      total_q  <= total_d;
      locked_q <= locked_d;
      ovf_q    <= ovf_d;
      if (cmd_i.div_init) begin
        dcnt_q <= '0;
      end else if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q + DCNT_W'(1);
      end
    end
  end

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && room) begin
      mem_q[cnt_q[IDX_W-1:0]] <= '{value:  item_i.flux_value,
                                  locked: item_i.is_locked,
                                  target: item_i.lock_target};
    end
    if (cmd_i.rd) begin
      rd_q <= mem_q[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      unl_q <= unl_d;
      tgt_q <= full - locked_q[TGT_W-1:0];
      uz_q  <= uz_d;
      neg_q <= neg_d;
      priority if (ovf_q) begin
        status_q <= STATUS_OVERFLOW;
      end else if (uz_d) begin
        status_q <= STATUS_ZERO_SUM;
      end else if (neg_d) begin
        status_q <= STATUS_NEG_TGT;
      end else begin
        status_q <= STATUS_OK;
      end
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(rd_q.value) * PROD_W'(tgt_q);
      if (rd_q.locked) begin
        res_q <= rd_q.target;
      end else if (uz_q) begin
        res_q <= rd_q.value;
      end else begin
        res_q <= '0;
      end
    end
    if (cmd_i.div_init) begin
      rem_q <= {{(SUM_W-TGT_W){1'b0}}, prod_hi};
      quo_q <= prod_q[DATA_W-1:0];
      res_q <= '1;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      if (sts_o.div_last) begin
        res_q <= quo_d;
      end
    end
  end

  assign sts_o.empty    = cnt_q == '0;
  assign sts_o.bypass   = rd_q.locked | uz_q | neg_q;
  assign sts_o.sat      = {{(SUM_W-TGT_W){1'b0}}, prod_hi} >= unl_q;
  assign sts_o.div_last = dcnt_q == DCNT_W'(DATA_W - 1);
  assign sts_o.last_idx = CNT_W'(idx_q) == (cnt_q - CNT_W'(1));

  assign result_o.scaled_value = res_q;
  assign result_o.final_result = sts_o.last_idx;
  assign result_o.status_code  = status_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_ENTRIES))
    else $error("entry count above capacity");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd |-> (CNT_W'(idx_q) < cnt_q))
    else $error("read beyond stored entries");

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.div_init && !sts_o.sat) || cmd_i.div_step |=> rem_q < unl_q)
    else $error("divider remainder not below divisor");

  a_clear_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> cnt_q == '0 && !ovf_q && total_q == '0 && locked_q == '0)
    else $error("vector state not cleared after final word");

endmodule

/* src/snl_ctrl.sv */
// ----------------------------------------------------------------------------
// snl_ctrl: sum normalizer controller
// Sequences load, setup, and per entry read, multiply, divide and emit.
// ----------------------------------------------------------------------------
module snl_ctrl import snl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  logic last_entry_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy,
  output logic res_strobe_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    busy         = 1'b1;
    res_strobe_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          if (last_entry_i) begin
            state_d = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        if (sts_i.empty) begin
          cmd_o.clear = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = sts_i.bypass ? ST_EMIT : ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        state_d        = sts_i.sat ? ST_EMIT : ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        res_strobe_o = 1'b1;
        if (sts_i.last_idx) begin
          cmd_o.clear = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          cmd_o.emit = 1'b1;
          state_d    = ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* src/sum_normalize_with_locked_entries.sv */
// ----------------------------------------------------------------------------
// sum_normalize_with_locked_entries: vector sum normalizer, locked entries
// Load: one word per cycle while busy is low; a non-last word gives no result.
// Close: the last word raises busy; a setup step, then per entry read,
//   multiply and emit (locked, zero-sum or negative target), with divider
//   init before emit (saturated), or divider init and 32 quotient steps
//   of the one-bit-per-cycle restoring divider before emit (divided).
// Results leave on a one-cycle strobe and cannot be stalled.
// Reset clears count, sums and overflow flag; entry memory holds no reset.
// ----------------------------------------------------------------------------
module sum_normalize_with_locked_entries import snl_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  item_t   item_i,
  output logic    res_strobe_o,
  output result_t result_o
);

  // Controller and datapath talk only through these two bundles.
  cmd_t cmd;
  sts_t sts;

  // The controller owns busy and the result strobe; a word is taken on
  // start while busy is low, and the last word hands control to the
  // normalize sequence.
  snl_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .last_entry_i (item_i.last_entry),
    .sts_i        (sts),
    .cmd_o        (cmd),
    .busy         (busy),
    .res_strobe_o (res_strobe_o)
  );

  // The datapath stores words, keeps the total and locked sums, computes
  // target = count << FRAC_BITS - locked sum, and for each unlocked entry
  // forms floor(value * target / unlocked sum), saturated to 32 bits.
  snl_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .item_i   (item_i),
    .sts_o    (sts),
    .result_o (result_o)
  );

endmodule

/* test/sum_normalize_with_locked_entries_tb.sv */
// ----------------------------------------------------------------------------
// sum_normalize_with_locked_entries_tb: self-checking bench for the normalizer
// Load vectors word by word and mirror each stored word in a local copy of
// the entry memory. On each closing word, compute the rescaled vector and
// queue it. Compare every strobed result field by field against the oldest
// queued entry. Cover single entries, locked and zero-sum mixes, negative
// targets, exact capacity and dropped words, then random vectors with gaps.
// ----------------------------------------------------------------------------
module sum_normalize_with_locked_entries_tb;
  import snl_pkg::*;

  localparam int CAP          = MAX_ENTRIES_DEF;
  localparam int QUIET_LIMIT  = 1000;  // cycles with no word moving either way
  localparam int DRAIN_CYCLES = 60;    // one divided entry plus setup, with margin
  localparam int WORD_BUDGET  = 210;

  // Content style of a random vector.
  typedef enum int {
    MIX_OK,         // locked values kept small so the target stays nonnegative
    MIX_ZERO_FREE,  // unlocked values all zero
    MIX_ANY         // any values, mostly negative targets
  } mix_e;

  logic    clk_i = 1'b0;
  logic    rst_ni;
  logic    start;
  logic    busy;
  item_t   item_i;
  logic    res_strobe_o;
  result_t result_o;

  // Mirror of the block state, updated on every accepted word.
  logic [DATA_W-1:0] held_flux   [CAP];
  logic              held_lock   [CAP];
  logic [DATA_W-1:0] held_target [CAP];
  int unsigned       held_count;
  logic [SUM_W-1:0]  sum_all;
  logic [SUM_W-1:0]  sum_locked;
  logic              dropped_seen;

  result_t     scaled_due[$];  // normalized entries still to come out
  int unsigned mismatch_count;
  int unsigned words_sent;
  int unsigned quiet_cycles;
  logic        no_gaps;

  sum_normalize_with_locked_entries u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .item_i       (item_i),
    .res_strobe_o (res_strobe_o),
    .result_o     (result_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Store one word in the mirror; on a closing word, push the whole rescaled
  // vector and clear the mirror.
  function automatic void load_and_normalize(input item_t w);
    logic [63:0] free_sum;
    logic [63:0] full_scale;
    logic [63:0] goal;
    logic [63:0] quot;
    logic        goal_neg;
    status_e     code;
    result_t     r;
    int unsigned idx;
    if (held_count < CAP) begin
      held_flux[held_count]   = w.flux_value;
      held_lock[held_count]   = w.is_locked;
      held_target[held_count] = w.lock_target;
      sum_all = sum_all + w.flux_value;
      if (w.is_locked) begin
        sum_locked = sum_locked + w.flux_value;
      end
      held_count++;
    end else begin
      // Past capacity: drop the word, only remember that it happened.
      dropped_seen = 1'b1;
    end
    if (!w.last_entry) begin
      return;
    end
    free_sum   = {26'd0, sum_all - sum_locked};
    full_scale = 64'(held_count) << FRAC_BITS_DEF;
    goal_neg   = {26'd0, sum_locked} > full_scale;
    goal       = goal_neg ? 64'd0 : full_scale - {26'd0, sum_locked};
    // Overflow wins the status, but the values follow the arithmetic alone.
    if (dropped_seen) begin
      code = STATUS_OVERFLOW;
    end else if (free_sum == 0) begin
      code = STATUS_ZERO_SUM;
    end else if (goal_neg) begin
      code = STATUS_NEG_TGT;
    end else begin
      code = STATUS_OK;
    end
    for (idx = 0; idx < held_count; idx++) begin
      if (held_lock[idx]) begin
        quot = {32'd0, held_target[idx]};
      end else if (free_sum == 0) begin
        quot = {32'd0, held_flux[idx]};
      end else if (goal_neg) begin
        quot = 64'd0;
      end else begin
        quot = ({32'd0, held_flux[idx]} * goal) / free_sum;
        if (quot > 64'hFFFF_FFFF) begin
          quot = 64'hFFFF_FFFF;
        end
      end
      r.scaled_value = quot[DATA_W-1:0];
      r.final_result = (idx + 1 == held_count);
      r.status_code  = code;
      scaled_due.push_back(r);
    end
    held_count   = 0;
    sum_all      = '0;
    sum_locked   = '0;
    dropped_seen = 1'b0;
  endfunction

  function automatic item_t mk_word(input logic [DATA_W-1:0] flux, input logic lck,
                                    input logic [DATA_W-1:0] tgt, input logic last);
    item_t w;
    w.flux_value  = flux;
    w.is_locked   = lck;
    w.lock_target = tgt;
    w.last_entry  = last;
    return w;
  endfunction

  // Spread values over full range, small Q values, the extremes and single bits.
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $urandom_range(0, 32'h0003_FFFF);
      2:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: return 32'h1 << $urandom_range(0, 31);
    endcase
  endfunction

  function automatic item_t rand_word(input mix_e mix, input logic last);
    item_t w;
    w.is_locked   = ($urandom_range(0, 3) == 0);
    w.lock_target = pick_value();
    w.last_entry  = last;
    case (mix)
      MIX_OK:        w.flux_value = w.is_locked ? $urandom_range(0, 32'h0001_0000)
                                                : pick_value();
      MIX_ZERO_FREE: w.flux_value = w.is_locked ? pick_value() : 32'h0;
      default:       w.flux_value = pick_value();
    endcase
    return w;
  endfunction

  // Send one word: idle for a drawn gap, then hold start until the block takes
  // it. Leave start high so back-to-back words never drop it in between.
  task automatic send_word(input item_t w);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= w;
    do @(posedge clk_i); while (busy);
    load_and_normalize(w);
    words_sent++;
  endtask

  task automatic send_vector(input mix_e mix, input int unsigned len);
    int unsigned k;
    no_gaps = ($urandom_range(0, 3) == 0);
    for (k = 0; k < len; k++) begin
      send_word(rand_word(mix, k + 1 == len));
    end
  endtask

  // Hold the sender off until every queued result has come out.
  task automatic settle_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (scaled_due.size() != 0) @(posedge clk_i);
  endtask

  // One-entry vectors: full-scale value, zero value, fully locked vector, unit value.
  task automatic test_single_entries();
    no_gaps = 1'b0;
    send_word(mk_word(32'hFFFF_FFFF, 1'b0, 32'h0, 1'b1));
    send_word(mk_word(32'h0, 1'b0, 32'hFFFF_FFFF, 1'b1));
    send_word(mk_word(32'h1, 1'b1, 32'hFFFF_FFFF, 1'b1));
    send_word(mk_word(32'h0001_0000, 1'b0, $urandom, 1'b1));
  endtask

  // Locked entries next to unlocked ones: positive, zero and negative targets.
  task automatic test_locked_mix();
    no_gaps = 1'b1;
    send_word(mk_word(32'h0, 1'b1, 32'hFFFF_FFFF, 1'b0));
    send_word(mk_word(32'h0000_8000, 1'b0, 32'h0, 1'b0));
    send_word(mk_word(32'h0001_8000, 1'b0, 32'h0, 1'b1));
    // locked value far above the entry count
    send_word(mk_word(32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0));
    send_word(mk_word(32'h5, 1'b0, 32'hFFFF_FFFF, 1'b0));
    send_word(mk_word(32'hFFFF_FFFF, 1'b0, 32'h0, 1'b1));
    no_gaps = 1'b0;
    // locked value exactly at the entry count: target zero
    send_word(mk_word(32'h0002_0000, 1'b1, 32'h1234_5678, 1'b0));
    send_word(mk_word(32'h7, 1'b0, 32'h0, 1'b1));
    // one above: target just negative
    send_word(mk_word(32'h0002_0001, 1'b1, 32'hFFFF_FFFF, 1'b0));
    send_word(mk_word(32'hFFFF_FFFF, 1'b0, 32'h0, 1'b1));
  endtask

  // Unlocked sum zero: unlocked entries pass through, locked take their target.
  task automatic test_zero_free_sum();
    no_gaps = 1'b1;
    send_word(mk_word(32'h0, 1'b0, 32'hFFFF_FFFF, 1'b0));
    send_word(mk_word(32'h0001_0000, 1'b1, 32'h0, 1'b0));
    send_word(mk_word(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0));
    send_word(mk_word(32'h0, 1'b0, 32'h0, 1'b1));
  endtask

  // Fill to capacity exactly, then overrun it with the closing word dropped.
  task automatic test_capacity();
    send_vector(mix_e'($urandom_range(0, 2)), CAP);
    settle_results();
    send_vector(MIX_OK, CAP + 2);
    settle_results();
  endtask

  // Mostly short vectors, a few longer ones; pause for a full drain now and then.
  task automatic test_random_vectors();
    int unsigned nvec;
    int unsigned len;
    nvec = 0;
    while (words_sent < WORD_BUDGET) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
      send_vector(mix_e'($urandom_range(0, 2)), len);
      nvec++;
      if (nvec % 5 == 0) begin
        settle_results();
      end
    end
  endtask

  // Check each strobed result against the oldest queued entry.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && res_strobe_o) begin
      if (scaled_due.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("unexpected result: value %h last %b status %0d",
                   result_o.scaled_value, result_o.final_result, result_o.status_code);
        end
        mismatch_count++;
      end else begin
        want = scaled_due.pop_front();
        if (result_o.scaled_value !== want.scaled_value ||
            result_o.final_result !== want.final_result ||
            result_o.status_code  !== want.status_code) begin
          if (mismatch_count < 10) begin
            $display("result mismatch: expected value %h last %b status %0d, got %h %b %0d",
                     want.scaled_value, want.final_result, want.status_code,
                     result_o.scaled_value, result_o.final_result, result_o.status_code);
          end
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: count cycles in which no word moves in either direction.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || res_strobe_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    start          = 1'b0;
    item_i         = '0;
    held_count     = 0;
    sum_all        = '0;
    sum_locked     = '0;
    dropped_seen   = 1'b0;
    words_sent     = 0;
    no_gaps        = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_single_entries();
    test_locked_mix();
    test_zero_free_sum();
    settle_results();
    test_capacity();
    test_random_vectors();

    // Drain, then give any stray result time to show up.
    settle_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && scaled_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
